>>> src/mba_pkg.sv
// Shared types, widths and codes for the mosaic block averaging block.
package mba_pkg;

  // Field and register widths.
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 3;
  localparam int SUM_W     = 20;
  localparam int CNT_W     = 13;
  localparam int OUT_POS_W = 10;
  localparam int BS_REG_W  = 7;
  localparam int DIM_REG_W = 11;
  localparam int ITER_W    = $clog2(SUM_W + 1);

  // Saturation limit of an average.
  localparam logic [CHAN_W-1:0] AVG_MAX = 8'd255;

  // Configuration register indexes (byte address divided by four).
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // One accumulator entry, one per block column.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum2;
    logic [SUM_W-1:0] sum1;
    logic [SUM_W-1:0] sum0;
  } mba_acc_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd;
    logic upd;
    logic div_avg;
    logic div_sync;
    logic load_sync;
    logic load_out;
  } mba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finish;
    logic div_busy;
    logic out_free;
  } mba_status_t;

  // Saturate a quotient to one colour byte.
  function automatic logic [CHAN_W-1:0] sat_avg(input logic [SUM_W-1:0] q);
    logic [CHAN_W-1:0] r;
    if (q > SUM_W'(AVG_MAX)) r = AVG_MAX;
    else r = q[CHAN_W-1:0];
    return r;
  endfunction

endpackage

>>> src/mba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> src/mba_div.sv
// Restoring divider, one quotient bit per cycle, one lane per colour channel.
module mba_div (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [mba_pkg::NUM_CHAN-1:0][mba_pkg::SUM_W-1:0] dividend,
  input  logic [mba_pkg::CNT_W-1:0]                 divisor,
  output logic                                      busy,
  output logic [mba_pkg::NUM_CHAN-1:0][mba_pkg::SUM_W-1:0] quotient,
  output logic [mba_pkg::NUM_CHAN-1:0][mba_pkg::CNT_W-1:0] remainder
);
  import mba_pkg::*;

  logic [ITER_W-1:0]                   cnt;
  logic [CNT_W-1:0]                    den;
  logic [NUM_CHAN-1:0][SUM_W-1:0]      quo_next;
  logic [NUM_CHAN-1:0][CNT_W-1:0]      rem_next;

  // One restoring step per lane: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    logic [CNT_W:0] rem_sh;
    logic           ge;
    for (int i = 0; i < NUM_CHAN; i++) begin
      rem_sh      = {remainder[i], quotient[i][SUM_W-1]};
      ge          = rem_sh >= {1'b0, den};
      rem_next[i] = ge ? CNT_W'(rem_sh - {1'b0, den}) : CNT_W'(rem_sh);
      quo_next[i] = {quotient[i][SUM_W-2:0], ge};
    end
  end

  // Iteration count and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ITER_W'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - ITER_W'(1);
      if (cnt == ITER_W'(1)) busy <= 1'b0;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      den       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= quo_next;
      remainder <= rem_next;
    end
  end

endmodule

>>> src/mba_datapath.sv
// Datapath: position counters, accumulator memory, dividers and result register.
module mba_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_BLOCK  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [mba_pkg::BS_REG_W-1:0]      block_size,
  input  logic [mba_pkg::DIM_REG_W-1:0]     image_width,
  input  logic [mba_pkg::DIM_REG_W-1:0]     image_height,
  input  logic [mba_pkg::CHAN_W-1:0]        chan0,
  input  logic [mba_pkg::CHAN_W-1:0]        chan1,
  input  logic [mba_pkg::CHAN_W-1:0]        chan2,
  input  logic                              frame_start,
  input  mba_pkg::mba_cmd_t                 cmd,
  output mba_pkg::mba_status_t              status,
  output logic                              blk_valid,
  input  logic                              blk_ready,
  output logic [mba_pkg::CHAN_W-1:0]        avg_chan0,
  output logic [mba_pkg::CHAN_W-1:0]        avg_chan1,
  output logic [mba_pkg::CHAN_W-1:0]        avg_chan2,
  output logic [mba_pkg::OUT_POS_W-1:0]     block_col,
  output logic [mba_pkg::OUT_POS_W-1:0]     block_row,
  output logic                              frame_done
);
  import mba_pkg::*;

  localparam int PXW = $clog2(MAX_WIDTH);
  localparam int PYW = $clog2(MAX_HEIGHT);
  localparam int XW  = $clog2(MAX_WIDTH + 1);
  localparam int YW  = $clog2(MAX_HEIGHT + 1);
  localparam int BSW = $clog2(MAX_BLOCK + 1);
  localparam int BXW = $clog2(MAX_BLOCK);
  localparam int ACC_W = $bits(mba_acc_t);

  // Effective (clamped) configuration.
  logic [BSW-1:0] bs;
  logic [XW-1:0]  w;
  logic [YW-1:0]  h;

  always_comb begin
    if (block_size == '0) bs = BSW'(1);
    else if (int'(block_size) > MAX_BLOCK) bs = BSW'(MAX_BLOCK);
    else bs = BSW'(block_size);
    if (image_width == '0) w = XW'(1);
    else if (int'(image_width) > MAX_WIDTH) w = XW'(MAX_WIDTH);
    else w = XW'(image_width);
    if (image_height == '0) h = YW'(1);
    else if (int'(image_height) > MAX_HEIGHT) h = YW'(MAX_HEIGHT);
    else h = YW'(image_height);
  end

  // Position of the next word: pixel column and row, offset inside the block,
  // block column and block row.
  logic [PXW-1:0] x;
  logic [PYW-1:0] y;
  logic [BXW-1:0] xb;
  logic [BXW-1:0] yb;
  logic [PXW-1:0] bc;
  logic [PYW-1:0] br;

  logic [CHAN_W-1:0] pix0, pix1, pix2;
  logic [PXW-1:0]    res_col;
  logic [PYW-1:0]    res_row;
  logic              res_last;

  logic restart;
  logic x_end, y_end, xb_end, yb_end;
  logic last_col, last_row;

  assign restart  = frame_start || (XW'(x) >= w) || (YW'(y) >= h);
  assign x_end    = XW'(x) == w - XW'(1);
  assign y_end    = YW'(y) == h - YW'(1);
  assign xb_end   = BSW'(xb) == bs - BSW'(1);
  assign yb_end   = BSW'(yb) == bs - BSW'(1);
  assign last_col = xb_end || x_end;
  assign last_row = yb_end || y_end;

  // Accumulator memory, one entry per block column.
  logic [ACC_W-1:0] ram_rdata;
  mba_acc_t         acc_rd;
  mba_acc_t         acc_new;

  assign acc_rd = mba_acc_t'(ram_rdata);

  // A band's first row starts each entry afresh; later rows add to it.
  always_comb begin
    if (yb == '0) begin
      acc_new.sum0 = SUM_W'(pix0);
      acc_new.sum1 = SUM_W'(pix1);
      acc_new.sum2 = SUM_W'(pix2);
      acc_new.cnt  = CNT_W'(1);
    end else begin
      acc_new.sum0 = acc_rd.sum0 + SUM_W'(pix0);
      acc_new.sum1 = acc_rd.sum1 + SUM_W'(pix1);
      acc_new.sum2 = acc_rd.sum2 + SUM_W'(pix2);
      acc_new.cnt  = acc_rd.cnt + CNT_W'(1);
    end
  end

  mba_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_WIDTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (bc),
    .wdata (ACC_W'(acc_new)),
    .re    (cmd.rd),
    .raddr (bc),
    .rdata (ram_rdata)
  );

  // Divider operands: block averages, or the block position after a
  // configuration change.
  logic                           div_start;
  logic [NUM_CHAN-1:0][SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0]               div_divisor;
  logic                           div_busy;
  logic [NUM_CHAN-1:0][SUM_W-1:0] div_quo;
  logic [NUM_CHAN-1:0][CNT_W-1:0] div_rem;

  assign div_start = cmd.div_avg || cmd.div_sync;

  always_comb begin
    if (cmd.div_sync) begin
      div_dividend[0] = SUM_W'(x);
      div_dividend[1] = SUM_W'(y);
      div_dividend[2] = '0;
      div_divisor     = CNT_W'(bs);
    end else begin
      div_dividend[0] = acc_new.sum0;
      div_dividend[1] = acc_new.sum1;
      div_dividend[2] = acc_new.sum2;
      // A count that has wrapped to zero divides as one.
      div_divisor     = (acc_new.cnt == '0) ? CNT_W'(1) : acc_new.cnt;
    end
  end

  mba_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      x  <= '0;
      y  <= '0;
      xb <= '0;
      yb <= '0;
      bc <= '0;
      br <= '0;
    end else if (cmd.accept && restart) begin
      x  <= '0;
      y  <= '0;
      xb <= '0;
      yb <= '0;
      bc <= '0;
      br <= '0;
    end else if (cmd.load_sync) begin
      bc <= PXW'(div_quo[0]);
      xb <= BXW'(div_rem[0]);
      br <= PYW'(div_quo[1]);
      yb <= BXW'(div_rem[1]);
    end else if (cmd.upd) begin
      if (x_end) begin
        x  <= '0;
        xb <= '0;
        bc <= '0;
        if (y_end) begin
          y  <= '0;
          yb <= '0;
          br <= '0;
        end else begin
          y <= y + PYW'(1);
          if (yb_end) begin
            yb <= '0;
            br <= br + PYW'(1);
          end else begin
            yb <= yb + BXW'(1);
          end
        end
      end else begin
        x <= x + PXW'(1);
        if (xb_end) begin
          xb <= '0;
          bc <= bc + PXW'(1);
        end else begin
          xb <= xb + BXW'(1);
        end
      end
    end
  end

  // Pixel capture and position of a finished block.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix0 <= chan0;
      pix1 <= chan1;
      pix2 <= chan2;
    end
    if (cmd.upd) begin
      res_col  <= bc;
      res_row  <= br;
      res_last <= x_end && y_end;
    end
  end

  // Result register; a new result may load on the edge the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (cmd.load_out) begin
      blk_valid <= 1'b1;
    end else if (blk_ready) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      avg_chan0  <= sat_avg(div_quo[0]);
      avg_chan1  <= sat_avg(div_quo[1]);
      avg_chan2  <= sat_avg(div_quo[2]);
      block_col  <= OUT_POS_W'(res_col);
      block_row  <= OUT_POS_W'(res_row);
      frame_done <= res_last;
    end
  end

  assign status.finish   = last_col && last_row;
  assign status.div_busy = div_busy;
  assign status.out_free = !blk_valid || blk_ready;

endmodule

>>> src/mba_ctrl.sv
// Controller: sequences each pixel word through read, update and, where it closes a block, division.
module mba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  logic                 cfg_write,
  input  mba_pkg::mba_status_t status,
  output mba_pkg::mba_cmd_t    cmd
);
  import mba_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SYNC   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_AVG    = 3'd4;

  logic [2:0] state, state_next;
  logic       sync_pending;

  assign pix_ready = (state == S_IDLE) && !sync_pending;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (sync_pending) begin
          cmd.div_sync = 1'b1;
          state_next   = S_SYNC;
        end else if (pix_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_SYNC: begin
        if (!status.div_busy) begin
          cmd.load_sync = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd = 1'b1;
        if (status.finish) begin
          cmd.div_avg = 1'b1;
          state_next  = S_AVG;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_AVG: begin
        if (!status.div_busy && status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // A register write calls for the block position to be worked out again.
  always_ff @(posedge clk) begin
    if (rst) sync_pending <= 1'b0;
    else if (cfg_write) sync_pending <= 1'b1;
    else if (cmd.div_sync) sync_pending <= 1'b0;
  end

`ifndef NO_ASSERTIONS
  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready) |-> (state == S_IDLE && !sync_pending))
    else $error("pixel word taken outside idle");

  a_load_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!status.div_busy && status.out_free))
    else $error("result loaded while divider busy or output full");

  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_avg || cmd.div_sync) |-> !status.div_busy)
    else $error("divider started while busy");

  a_read_then_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_UPDATE && cmd.upd))
    else $error("memory read not followed by update");
`endif

endmodule

>>> src/mosaic_block_average.sv
// Top level of the mosaic block averaging block: register port and sub-blocks.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------------
//   pixel   | pix_valid / pix_ready  | chan0, chan1, chan2, frame_start
//   block   | blk_valid / blk_ready  | avg_chan0..2, block_col, block_row, frame_done
//   config  | APB psel/penable/...   | block_size, image_width, image_height
//
// A pixel word passes through accept, accumulator memory read, then update and write.
// A word that closes a block goes on through the bit-serial divider and the
// result load, plus any wait for the result register to be taken.
// After each register write the block position is recomputed by the same divider
// before the next word is taken.
// Reset is synchronous; the accumulator memory is not cleared, as each band's first
// row writes its entries afresh.
module mosaic_block_average #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_BLOCK  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Pixel words
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  logic [mba_pkg::CHAN_W-1:0]        chan0,
  input  logic [mba_pkg::CHAN_W-1:0]        chan1,
  input  logic [mba_pkg::CHAN_W-1:0]        chan2,
  input  logic                              frame_start,
  // Block words
  output logic                              blk_valid,
  input  logic                              blk_ready,
  output logic [mba_pkg::CHAN_W-1:0]        avg_chan0,
  output logic [mba_pkg::CHAN_W-1:0]        avg_chan1,
  output logic [mba_pkg::CHAN_W-1:0]        avg_chan2,
  output logic [mba_pkg::OUT_POS_W-1:0]     block_col,
  output logic [mba_pkg::OUT_POS_W-1:0]     block_row,
  output logic                              frame_done
);
  import mba_pkg::*;

  logic [BS_REG_W-1:0]  block_size;
  logic [DIM_REG_W-1:0] image_width;
  logic [DIM_REG_W-1:0] image_height;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  mba_cmd_t    cmd;
  mba_status_t status;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= BS_REG_W'(8);
      image_width  <= DIM_REG_W'(360);
      image_height <= DIM_REG_W'(240);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_BLOCK_SIZE:   block_size   <= pwdata[BS_REG_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_BLOCK_SIZE:   prdata = 32'(block_size);
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  mba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .cfg_write (cfg_write),
    .status    (status),
    .cmd       (cmd)
  );

  mba_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .block_size   (block_size),
    .image_width  (image_width),
    .image_height (image_height),
    .chan0        (chan0),
    .chan1        (chan1),
    .chan2        (chan2),
    .frame_start  (frame_start),
    .cmd          (cmd),
    .status       (status),
    .blk_valid    (blk_valid),
    .blk_ready    (blk_ready),
    .avg_chan0    (avg_chan0),
    .avg_chan1    (avg_chan1),
    .avg_chan2    (avg_chan2),
    .block_col    (block_col),
    .block_row    (block_row),
    .frame_done   (frame_done)
  );

endmodule

>>> bench/mosaic_block_average_tb.sv
// Self-checking testbench for the mosaic block averaging block.
module mosaic_block_average_tb;
  import mba_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int MAX_BLK = 64;
  localparam int ITEM_TARGET = 1100;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_LIMIT = 50;

  // One pixel word and one block word as the ports carry them.
  typedef struct packed {
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic              frame_start;
  } pixel_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    avg0;
    logic [CHAN_W-1:0]    avg1;
    logic [CHAN_W-1:0]    avg2;
    logic [OUT_POS_W-1:0] col;
    logic [OUT_POS_W-1:0] row;
    logic                 done;
  } block_word_t;

  // Directed rows are either a register write or a pixel word.
  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [31:0]            reg_val;
    pixel_word_t            px;
    logic                   typed;
    block_word_t            want;
  } dir_row_t;

  localparam pixel_word_t NO_PIXEL = '0;
  localparam block_word_t NO_BLOCK = '0;

  // Directed rows: tiny blocks first, where each average is the pixel itself,
  // then clamped registers, a position pushed off the image, and clipped blocks.
  localparam dir_row_t DIR_TABLE [33] = '{
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0,    '{8'd12, 8'd34, 8'd56, 1'b0}, 1'b0, NO_BLOCK},
    '{ROW_CFG, REG_BLOCK_SIZE,   32'd1,    NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_CFG, REG_IMAGE_WIDTH,  32'd3,    NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'd2,    NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd255, 8'd0, 8'd128, 1'b1}, 1'b1,
      '{8'd255, 8'd0, 8'd128, 10'd0, 10'd0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd0, 8'd255, 8'd1, 1'b0}, 1'b1,
      '{8'd0, 8'd255, 8'd1, 10'd1, 10'd0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd170, 8'd85, 8'd254, 1'b0}, 1'b1,
      '{8'd170, 8'd85, 8'd254, 10'd2, 10'd0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd1, 8'd2, 8'd3, 1'b0}, 1'b1,
      '{8'd1, 8'd2, 8'd3, 10'd0, 10'd1, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd4, 8'd5, 8'd6, 1'b0}, 1'b1,
      '{8'd4, 8'd5, 8'd6, 10'd1, 10'd1, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd7, 8'd8, 8'd9, 1'b0}, 1'b1,
      '{8'd7, 8'd8, 8'd9, 10'd2, 10'd1, 1'b1}},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd10, 8'd20, 8'd30, 1'b0}, 1'b1,
      '{8'd10, 8'd20, 8'd30, 10'd0, 10'd0, 1'b0}},
    '{ROW_CFG, REG_BLOCK_SIZE,   32'd0,    NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd9, 8'd99, 8'd199, 1'b1}, 1'b1,
      '{8'd9, 8'd99, 8'd199, 10'd0, 10'd0, 1'b0}},
    '{ROW_CFG, REG_IMAGE_WIDTH,  32'd0,    NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd50, 8'd60, 8'd70, 1'b0}, 1'b1,
      '{8'd50, 8'd60, 8'd70, 10'd0, 10'd0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd80, 8'd90, 8'd100, 1'b0}, 1'b1,
      '{8'd80, 8'd90, 8'd100, 10'd0, 10'd1, 1'b1}},
    '{ROW_CFG, REG_BLOCK_SIZE,   32'd127,  NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_CFG, REG_IMAGE_WIDTH,  32'd2047, NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'd2047, NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, NO_BLOCK},
    '{ROW_CFG, REG_BLOCK_SIZE,   32'd2,    NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_CFG, REG_IMAGE_WIDTH,  32'd3,    NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'd3,    NO_PIXEL, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd255, 8'd0, 8'd0, 1'b0}, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd1, 8'd1, 8'd1, 1'b0}, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd0, 8'd255, 8'd0, 1'b0}, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd3, 8'd5, 8'd7, 1'b0}, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd128, 8'd64, 8'd32, 1'b0}, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd200, 8'd100, 8'd50, 1'b0}, 1'b0, NO_BLOCK},
    '{ROW_PIX, REG_BLOCK_SIZE, 32'd0, '{8'd0, 8'd0, 8'd255, 1'b0}, 1'b0, NO_BLOCK}
  };

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic pix_valid = 1'b0;
  logic pix_ready;
  logic [CHAN_W-1:0] chan0 = '0;
  logic [CHAN_W-1:0] chan1 = '0;
  logic [CHAN_W-1:0] chan2 = '0;
  logic frame_start = 1'b0;
  logic blk_valid;
  logic blk_ready = 1'b0;
  logic [CHAN_W-1:0] avg_chan0;
  logic [CHAN_W-1:0] avg_chan1;
  logic [CHAN_W-1:0] avg_chan2;
  logic [OUT_POS_W-1:0] block_col;
  logic [OUT_POS_W-1:0] block_row;
  logic frame_done;

  // Predictor state: register copies, position and per-column accumulators.
  logic [BS_REG_W-1:0]  set_block = 7'd8;
  logic [DIM_REG_W-1:0] set_width = 11'd360;
  logic [DIM_REG_W-1:0] set_height = 11'd240;
  int unsigned pos_x = 0;
  int unsigned pos_y = 0;
  logic [SUM_W-1:0] acc_sum0 [MAX_W];
  logic [SUM_W-1:0] acc_sum1 [MAX_W];
  logic [SUM_W-1:0] acc_sum2 [MAX_W];
  logic [CNT_W-1:0] acc_count [MAX_W];

  block_word_t pending_blocks [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned blocks_seen = 0;
  int unsigned settings_used = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned cycle_count = 0;

  mosaic_block_average #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H),
    .MAX_BLOCK(MAX_BLK)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .chan0(chan0),
    .chan1(chan1),
    .chan2(chan2),
    .frame_start(frame_start),
    .blk_valid(blk_valid),
    .blk_ready(blk_ready),
    .avg_chan0(avg_chan0),
    .avg_chan1(avg_chan1),
    .avg_chan2(avg_chan2),
    .block_col(block_col),
    .block_row(block_row),
    .frame_done(frame_done)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Registers outside their range act as the nearest legal value.
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Truncating average, saturated to one colour byte; a zero count divides as one.
  function automatic logic [CHAN_W-1:0] limit_average(input int unsigned sum,
                                                      input int unsigned cnt);
    int unsigned q;
    q = sum / ((cnt == 0) ? 1 : cnt);
    return (q > 255) ? 8'd255 : q[CHAN_W-1:0];
  endfunction

  // Adds one pixel to its block column and returns 1 when that closes a block.
  function automatic bit accumulate_pixel(input pixel_word_t px, output block_word_t blk);
    int unsigned bs, w, h, x, y, bc;
    bit closes;
    bs = clamp_dim(32'(set_block), MAX_BLK);
    w = clamp_dim(32'(set_width), MAX_W);
    h = clamp_dim(32'(set_height), MAX_H);
    closes = 1'b0;
    blk = NO_BLOCK;
    if (px.frame_start || pos_x >= w || pos_y >= h) begin
      pos_x = 0;
      pos_y = 0;
    end
    x = pos_x;
    y = pos_y;
    bc = (x / bs) % MAX_W;
    // The first row of a band starts each column afresh.
    if (y % bs == 0) begin
      acc_sum0[bc] = SUM_W'(px.chan0);
      acc_sum1[bc] = SUM_W'(px.chan1);
      acc_sum2[bc] = SUM_W'(px.chan2);
      acc_count[bc] = CNT_W'(1);
    end else begin
      acc_sum0[bc] = acc_sum0[bc] + SUM_W'(px.chan0);
      acc_sum1[bc] = acc_sum1[bc] + SUM_W'(px.chan1);
      acc_sum2[bc] = acc_sum2[bc] + SUM_W'(px.chan2);
      acc_count[bc] = acc_count[bc] + CNT_W'(1);
    end
    // A block closes on its last column and last row, clipped at the image edges.
    if ((x % bs == bs - 1 || x == w - 1) && (y % bs == bs - 1 || y == h - 1)) begin
      blk.avg0 = limit_average(32'(acc_sum0[bc]), 32'(acc_count[bc]));
      blk.avg1 = limit_average(32'(acc_sum1[bc]), 32'(acc_count[bc]));
      blk.avg2 = limit_average(32'(acc_sum2[bc]), 32'(acc_count[bc]));
      blk.col = bc[OUT_POS_W-1:0];
      blk.row = OUT_POS_W'(y / bs);
      blk.done = (x == w - 1) && (y == h - 1);
      closes = 1'b1;
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    pos_x = x;
    pos_y = y;
    return closes;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Register write over the configuration port: setup cycle, then access cycle.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BLOCK_SIZE:   set_block = value[BS_REG_W-1:0];
      REG_IMAGE_WIDTH:  set_width = value[DIM_REG_W-1:0];
      REG_IMAGE_HEIGHT: set_height = value[DIM_REG_W-1:0];
      default: ;
    endcase
  endtask

  // Lets every expected block word arrive, then lets words without a result settle.
  task automatic wait_idle();
    pix_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offers one pixel word and, once it is taken, records what it should produce.
  task automatic send_pixel(input pixel_word_t px, input bit typed, input block_word_t want);
    block_word_t blk;
    bit closes;
    if (items_sent < ITEM_TARGET / 3) begin
      tx_idle_pct = 23;
      rx_idle_pct = 74;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 74;
      rx_idle_pct = 23;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    chan0 <= px.chan0;
    chan1 <= px.chan1;
    chan2 <= px.chan2;
    frame_start <= px.frame_start;
    do @(posedge clk); while (!pix_ready);
    items_sent++;
    closes = accumulate_pixel(px, blk);
    if (typed) pending_blocks.push_back(want);
    else if (closes) pending_blocks.push_back(blk);
  endtask

  // One random setting followed by its pixel stream.
  task automatic run_phase();
    int unsigned pick, bs_v, w_v, h_v, frame_len, count, cw, ch;
    bit must_start;
    pixel_word_t px;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      // Widest image, largest blocks, one row: results every block width.
      bs_v = ($urandom_range(0, 1) == 1) ? 64 : $urandom_range(65, 127);
      w_v = ($urandom_range(0, 1) == 1) ? 1024 : $urandom_range(1025, 2047);
      h_v = 1;
      count = 2 * MAX_BLK + $urandom_range(0, 12);
      frame_len = count;
    end else if (pick == 1) begin
      // Tallest image, largest blocks, one or two columns.
      bs_v = ($urandom_range(0, 1) == 1) ? 64 : $urandom_range(65, 127);
      w_v = $urandom_range(1, 2);
      h_v = ($urandom_range(0, 1) == 1) ? 1024 : $urandom_range(1025, 2047);
      count = 2 * MAX_BLK * w_v + $urandom_range(0, 6);
      frame_len = count;
    end else begin
      bs_v = $urandom_range(0, 8);
      w_v = $urandom_range(0, 16);
      h_v = $urandom_range(0, 12);
      frame_len = clamp_dim(w_v, MAX_W) * clamp_dim(h_v, MAX_H);
      count = frame_len * $urandom_range(1, 2);
      if ($urandom_range(0, 5) == 0) count = count - $urandom_range(0, frame_len - 1);
    end
    // The last phase stops at the item target.
    if (count > ITEM_TARGET - items_sent) count = ITEM_TARGET - items_sent;

    wait_idle();
    write_register(REG_BLOCK_SIZE, bs_v);
    write_register(REG_IMAGE_WIDTH, w_v);
    write_register(REG_IMAGE_HEIGHT, h_v);
    settings_used++;

    // Without a frame start, only a position at the origin or off the new image is safe.
    cw = clamp_dim(32'(set_width), MAX_W);
    ch = clamp_dim(32'(set_height), MAX_H);
    must_start = !((pos_x == 0 && pos_y == 0) || pos_x >= cw || pos_y >= ch);

    for (int unsigned i = 0; i < count; i++) begin
      px.chan0 = CHAN_W'($urandom_range(0, 255));
      px.chan1 = CHAN_W'($urandom_range(0, 255));
      px.chan2 = CHAN_W'($urandom_range(0, 255));
      if (i == 0) px.frame_start = must_start || ($urandom_range(0, 1) == 1);
      else if (i % frame_len == 0) px.frame_start = ($urandom_range(0, 7) != 0);
      else px.frame_start = ($urandom_range(0, 59) == 0);
      send_pixel(px, 1'b0, NO_BLOCK);
    end
  endtask

  // Block word checker and receiver stalls.
  always @(posedge clk) begin : block_check
    block_word_t want;
    if (rst) begin
      blk_ready <= 1'b0;
    end else begin
      if (blk_valid && blk_ready) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch("unexpected block word", 32'(block_col), 0);
        end else begin
          want = pending_blocks.pop_front();
          blocks_seen++;
          if (avg_chan0 !== want.avg0)
            report_mismatch("avg_chan0", 32'(avg_chan0), 32'(want.avg0));
          if (avg_chan1 !== want.avg1)
            report_mismatch("avg_chan1", 32'(avg_chan1), 32'(want.avg1));
          if (avg_chan2 !== want.avg2)
            report_mismatch("avg_chan2", 32'(avg_chan2), 32'(want.avg2));
          if (block_col !== want.col)
            report_mismatch("block_col", 32'(block_col), 32'(want.col));
          if (block_row !== want.row)
            report_mismatch("block_row", 32'(block_row), 32'(want.row));
          if (frame_done !== want.done)
            report_mismatch("frame_done", 32'(frame_done), 32'(want.done));
        end
      end
      blk_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d block words outstanding",
               cycle_count, pending_blocks.size());
      $display("FAIL mosaic_block_average");
      $finish;
    end
  end

  // Reset, directed rows, random settings, then the final verdict.
  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      acc_sum0[i] = '0;
      acc_sum1[i] = '0;
      acc_sum2[i] = '0;
      acc_count[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        wait_idle();
        write_register(DIR_TABLE[i].reg_idx, DIR_TABLE[i].reg_val);
        settings_used++;
      end else begin
        send_pixel(DIR_TABLE[i].px, DIR_TABLE[i].typed, DIR_TABLE[i].want);
      end
    end

    while (items_sent < ITEM_TARGET) run_phase();

    wait_idle();
    $display("Covered %0d pixel words under %0d register writes and phases,", items_sent,
             settings_used);
    $display("with %0d block words checked field by field.", blocks_seen);
    if (mismatches == 0) begin
      $display("PASS mosaic_block_average");
    end else begin
      $display("FAIL mosaic_block_average");
    end
    $finish;
  end

endmodule
